// ===== design/xbar_islip_pkg.sv =====
// ----------------------------------------------------------------------------
// Crossbar iSLIP scheduler package
// Shared sizes, field widths and record types for the scheduler lanes,
// the output arbiters and the result merge stage.
// ----------------------------------------------------------------------------
package xbar_islip_pkg;

  localparam int PORTS       = 8;
  localparam int BUFFER_MAX  = 16;
  localparam int STAMP_BITS  = 16;
  localparam int FIELD_PORTS = 8;

  localparam int PORT_W  = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int ADDR_W  = (BUFFER_MAX > 1) ? $clog2(BUFFER_MAX) : 1;
  localparam int COUNT_W = $clog2(BUFFER_MAX + 1);
  localparam int OUT_N   = (PORTS < FIELD_PORTS) ? PORTS : FIELD_PORTS;

  localparam int MASK_W  = 8;
  localparam int DEST_W  = 24;
  localparam int GROUP_W = 3;
  localparam int DELAY_W = 19;
  localparam int DROP_W  = 4;
  localparam int LIMIT_W = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4);

  typedef struct packed {
    logic [STAMP_BITS-1:0] stamp;
    logic [PORT_W-1:0]     dest;
  } entry_t;

  typedef struct packed {
    logic              valid;
    logic [PORT_W-1:0] dest;
  } req_t;

  typedef struct packed {
    logic              valid;
    logic [PORT_W-1:0] src;
  } gnt_t;

  function automatic logic [PORT_W-1:0] dest_wrap(input logic [GROUP_W-1:0] d);
    logic [GROUP_W:0] v;
    v = {1'b0, d};
    for (int k = 0; k < 8; k++) begin
      if (32'(v) >= PORTS) begin
        v = v - (GROUP_W+1)'(PORTS);
      end
    end
    return PORT_W'(v);
  endfunction

endpackage

// ===== design/xbar_islip_lane.sv =====
// ----------------------------------------------------------------------------
// Input lane
// One input port's FIFO: enqueues the arriving packet with its stamp,
// drops it when the FIFO already holds limit entries, presents the
// head-of-line request and dequeues the head when an output grants it.
// ----------------------------------------------------------------------------
module xbar_islip_lane
  import xbar_islip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  arrive,
  input  logic [PORT_W-1:0]     dest_in,
  input  logic [STAMP_BITS-1:0] stamp,
  input  logic [COUNT_W-1:0]    limit,
  input  logic                  grant,
  output req_t                  req,
  output logic [STAMP_BITS-1:0] head_stamp,
  output logic                  drop
);

  entry_t              mem [BUFFER_MAX];
  logic [ADDR_W-1:0]   head;
  logic [COUNT_W-1:0]  count;
  logic [ADDR_W-1:0]   head_next;
  logic [COUNT_W-1:0]  count_next;
  logic [ADDR_W-1:0]   tail;
  logic [ADDR_W:0]     tail_sum;
  logic                enq;
  entry_t              new_entry;
  entry_t              head_entry;

  assign new_entry.stamp = stamp;
  assign new_entry.dest  = dest_in;
  assign enq  = arrive && (count < limit);
  assign drop = arrive && !(count < limit);

  always_comb begin
    tail_sum = {1'b0, head} + (ADDR_W+1)'(count);
    if (32'(tail_sum) >= BUFFER_MAX) begin
      tail_sum = tail_sum - (ADDR_W+1)'(BUFFER_MAX);
    end
    tail = ADDR_W'(tail_sum);
  end

  always_comb begin
    if (count == '0) begin
      head_entry = new_entry;
      req.valid  = enq;
    end else begin
      head_entry = mem[head];
      req.valid  = 1'b1;
    end
    req.dest   = head_entry.dest;
    head_stamp = head_entry.stamp;
  end

  always_comb begin
    head_next  = head;
    count_next = count + COUNT_W'(enq);
    if (grant) begin
      count_next = count_next - COUNT_W'(1);
      if (head == ADDR_W'(BUFFER_MAX - 1)) begin
        head_next = '0;
      end else begin
        head_next = head + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (step) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && enq) begin
      mem[tail] <= new_entry;
    end
  end

endmodule

// ===== design/xbar_islip_arb.sv =====
// ----------------------------------------------------------------------------
// Output arbiter
// Round-robin grant for one output: picks the first requesting input at or
// after the grant pointer and moves the pointer past the grantee.
// ----------------------------------------------------------------------------
module xbar_islip_arb
  import xbar_islip_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [PORT_W-1:0] out_id,
  input  req_t              req [PORTS],
  output gnt_t              gnt
);

  logic [PORT_W-1:0] ptr;
  logic [PORT_W-1:0] ptr_next;
  logic [PORT_W:0]   idx;

  always_comb begin
    gnt.valid = 1'b0;
    gnt.src   = '0;
    for (int k = 0; k < PORTS; k++) begin
      idx = {1'b0, ptr} + (PORT_W+1)'(k);
      if (32'(idx) >= PORTS) begin
        idx = idx - (PORT_W+1)'(PORTS);
      end
      if (!gnt.valid && req[PORT_W'(idx)].valid && req[PORT_W'(idx)].dest == out_id) begin
        gnt.valid = 1'b1;
        gnt.src   = PORT_W'(idx);
      end
    end
  end

  always_comb begin
    if (32'(gnt.src) == PORTS - 1) begin
      ptr_next = '0;
    end else begin
      ptr_next = gnt.src + PORT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (step && gnt.valid) begin
      ptr <= ptr_next;
    end
  end

endmodule

// ===== design/xbar_islip_merge.sv =====
// ----------------------------------------------------------------------------
// Result merge
// Combines the grants of all outputs into the sent mask, source groups,
// delay sum and drop count, and holds results in an output register with
// a skid stage.
// ----------------------------------------------------------------------------
module xbar_islip_merge
  import xbar_islip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  gnt_t                  gnt [PORTS],
  input  logic [STAMP_BITS-1:0] head_stamp [PORTS],
  input  logic [PORTS-1:0]      drops,
  input  logic [STAMP_BITS-1:0] stamp,
  output logic                  accept_ok,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [MASK_W-1:0]     sent_mask,
  output logic [DEST_W-1:0]     sent_sources,
  output logic [DELAY_W-1:0]    delay_sum,
  output logic [DROP_W-1:0]     drop_count
);

  typedef struct packed {
    logic [MASK_W-1:0]  mask;
    logic [DEST_W-1:0]  sources;
    logic [DELAY_W-1:0] delay;
    logic [DROP_W-1:0]  drops;
  } result_t;

  result_t               res;
  result_t               out_reg;
  result_t               skid;
  logic                  skid_valid;
  logic                  take;
  logic [STAMP_BITS-1:0] gap;

  always_comb begin
    res = '0;
    for (int j = 0; j < OUT_N; j++) begin
      gap = stamp - head_stamp[gnt[j].src];
      if (gnt[j].valid) begin
        res.mask[j] = 1'b1;
        res.sources[GROUP_W*j +: GROUP_W] = GROUP_W'(gnt[j].src);
        res.delay = res.delay + DELAY_W'(gap);
      end
    end
    for (int i = 0; i < OUT_N; i++) begin
      res.drops = res.drops + DROP_W'(drops[i]);
    end
  end

  assign take      = out_valid && out_ready;
  assign accept_ok = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid && take) begin
      skid_valid <= 1'b0;
    end else if (step) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid && take) begin
      out_reg <= skid;
    end else if (step) begin
      if (!out_valid || take) begin
        out_reg <= res;
      end else begin
        skid <= res;
      end
    end
  end

  assign sent_mask    = out_reg.mask;
  assign sent_sources = out_reg.sources;
  assign delay_sum    = out_reg.delay;
  assign drop_count   = out_reg.drops;

endmodule

// ===== design/crossbar_switch_islip_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// Crossbar iSLIP scheduler core
// Input FIFOs per port with a single-iteration round-robin output grant.
// ----------------------------------------------------------------------------
// Each input beat is one time slot; a new slot can be accepted every cycle
// while in_ready is high. All input lanes enqueue and all output arbiters
// grant in parallel for each slot. The result goes to the merge stage's
// output register, or to one skid entry while an earlier result waits, so
// the next slot can be accepted meanwhile. The input FIFOs need no clearing
// after reset. The user must write buffer_limit through cfg_write and
// cfg_data only while the block is idle; the block does not enforce this.
module crossbar_switch_islip_scheduler_core
  import xbar_islip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [LIMIT_W-1:0]    cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [MASK_W-1:0]     arrival_mask,
  input  logic [DEST_W-1:0]     arrival_dests,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [MASK_W-1:0]     sent_mask,
  output logic [DEST_W-1:0]     sent_sources,
  output logic [DELAY_W-1:0]    delay_sum,
  output logic [DROP_W-1:0]     drop_count
);

  logic [LIMIT_W-1:0]    buffer_limit;
  logic [STAMP_BITS-1:0] slot_counter;
  logic [COUNT_W-1:0]    limit;
  logic                  step;
  req_t                  req [PORTS];
  gnt_t                  gnt [PORTS];
  logic [STAMP_BITS-1:0] head_stamp [PORTS];
  logic [PORTS-1:0]      drops;
  logic [PORTS-1:0]      granted;

  assign step = in_valid && in_ready;

  always_comb begin
    if (32'(buffer_limit) > BUFFER_MAX) begin
      limit = COUNT_W'(BUFFER_MAX);
    end else begin
      limit = COUNT_W'(buffer_limit);
    end
  end

  always_comb begin
    granted = '0;
    for (int j = 0; j < PORTS; j++) begin
      if (gnt[j].valid) begin
        granted[gnt[j].src] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_limit <= LIMIT_RESET;
      slot_counter <= '0;
    end else begin
      if (cfg_write) begin
        buffer_limit <= cfg_data;
      end
      if (step) begin
        slot_counter <= slot_counter + STAMP_BITS'(1);
      end
    end
  end

  for (genvar i = 0; i < PORTS; i++) begin : g_lane
    logic              arrive;
    logic [PORT_W-1:0] dest_in;
    if (i < FIELD_PORTS) begin : g_field
      assign arrive  = arrival_mask[i];
      assign dest_in = dest_wrap(arrival_dests[GROUP_W*i +: GROUP_W]);
    end else begin : g_none
      assign arrive  = 1'b0;
      assign dest_in = '0;
    end
    xbar_islip_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .step       (step),
      .arrive     (arrive),
      .dest_in    (dest_in),
      .stamp      (slot_counter),
      .limit      (limit),
      .grant      (granted[i]),
      .req        (req[i]),
      .head_stamp (head_stamp[i]),
      .drop       (drops[i])
    );
  end

  for (genvar j = 0; j < PORTS; j++) begin : g_arb
    xbar_islip_arb u_arb (
      .clk    (clk),
      .rst    (rst),
      .step   (step),
      .out_id (PORT_W'(j)),
      .req    (req),
      .gnt    (gnt[j])
    );
  end

  xbar_islip_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .gnt          (gnt),
    .head_stamp   (head_stamp),
    .drops        (drops),
    .stamp        (slot_counter),
    .accept_ok    (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sent_mask    (sent_mask),
    .sent_sources (sent_sources),
    .delay_sum    (delay_sum),
    .drop_count   (drop_count)
  );

endmodule
